### rtl/spc_pkg.sv
// Shared constants, types and the rate band lookup for the sample pacer.
// Used by the core, the serial arithmetic unit and the port checker.
// No dependencies.
package spc_pkg;

	localparam int NOW_W         = 32;
	localparam int RATE_W        = 16;
	localparam int CODE_W        = 4;
	localparam int MS_PER_SECOND = 1000;
	localparam int MS_W          = $clog2(MS_PER_SECOND + 1);
	localparam int PROD_W        = NOW_W + RATE_W;
	localparam int ITER_MAX      = (RATE_W > MS_W) ? RATE_W : MS_W;
	localparam int CNT_W         = $clog2(ITER_MAX + 1);

	localparam logic [RATE_W-1:0] RATE_RESET = {RATE_W{1'b1}};

	// Converter data-rate codes.
	localparam logic [CODE_W-1:0] CODE_UNLIMITED = 4'hF;
	localparam int NUM_BANDS = 9;
	localparam int BAND_LIMIT [NUM_BANDS] = '{5, 10, 20, 40, 80, 160, 320, 640, 1000};

	// Start requests from the core to the arithmetic unit.
	typedef struct packed {
		logic start_mul;
		logic start_div;
	} ar_ctl_t;

	// Status of the arithmetic unit.
	typedef struct packed {
		logic busy;
		logic done;
	} ar_sts_t;

	// Maps the signed rate to the converter's data-rate code.
	function automatic logic [CODE_W-1:0] rate_band(input logic signed [RATE_W-1:0] r);
		logic [CODE_W-1:0] code;
		code = CODE_UNLIMITED;
		if (r != '0) begin
			for (int i = NUM_BANDS - 1; i >= 0; i--) begin
				if (int'(r) <= BAND_LIMIT[i]) begin
					code = CODE_W'(i);
				end
			end
		end
		return code;
	endfunction

endpackage

### rtl/spc_serial_arith.sv
// Bit-serial multiplier (32 x 16, one multiplier bit per cycle) and restoring
// divider of MS_PER_SECOND by the rate (one quotient bit per cycle).
// Depends on spc_pkg.
module spc_serial_arith import spc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  ar_ctl_t             ctl,
	input  logic [NOW_W-1:0]    op_a,
	input  logic [RATE_W-1:0]   op_b,
	output ar_sts_t             sts,
	output logic [PROD_W-1:0]   product,
	output logic [MS_W-1:0]     quotient
);

	typedef enum logic {MODE_MUL, MODE_DIV} mode_t;

	logic              busy_q;
	logic              done_q;
	mode_t             mode_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NOW_W-1:0]  a_q;
	logic [RATE_W-1:0] b_q;
	logic [NOW_W:0]    hi_q;
	logic [RATE_W-1:0] lo_q;
	logic [RATE_W-1:0] rem_q;
	logic [MS_W-1:0]   dvd_q;
	logic [MS_W-1:0]   quo_q;

	logic [NOW_W:0]    mul_sum;
	logic [RATE_W-1:0] trial;
	logic              fits;
	logic              last_iter;

	// One shift-add step and one trial-subtract step.
	always_comb begin
		mul_sum   = hi_q + (lo_q[0] ? {1'b0, a_q} : '0);
		trial     = {rem_q[RATE_W-2:0], dvd_q[MS_W-1]};
		fits      = (trial >= b_q);
		last_iter = (mode_q == MODE_MUL) ? (cnt_q == CNT_W'(RATE_W - 1))
		                                 : (cnt_q == CNT_W'(MS_W - 1));
	end

	// Sequencing: step counter, busy flag and a done pulse after the last step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			mode_q <= MODE_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start_mul) begin
				busy_q <= 1'b1;
				mode_q <= MODE_MUL;
				cnt_q  <= '0;
			end else if (ctl.start_div) begin
				busy_q <= 1'b1;
				mode_q <= MODE_DIV;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_iter) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath shift registers.
	always_ff @(posedge clk) begin
		if (ctl.start_mul) begin
			a_q  <= op_a;
			hi_q <= '0;
			lo_q <= op_b;
		end else if (ctl.start_div) begin
			b_q   <= op_b;
			rem_q <= '0;
			dvd_q <= MS_W'(MS_PER_SECOND);
			quo_q <= '0;
		end else if (busy_q) begin
			if (mode_q == MODE_MUL) begin
				hi_q <= {1'b0, mul_sum[NOW_W:1]};
				lo_q <= {mul_sum[0], lo_q[RATE_W-1:1]};
			end else begin
				rem_q <= fits ? (trial - b_q) : trial;
				quo_q <= {quo_q[MS_W-2:0], fits};
				dvd_q <= {dvd_q[MS_W-2:0], 1'b0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign product  = {hi_q[NOW_W-1:0], lo_q};
	assign quotient = quo_q;

endmodule

### rtl/sample_pacer_with_catchup_core.sv
// Top level of the sample pacer: timestamp state, rate register, control FSM.
// Depends on spc_pkg and spc_serial_arith.
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    now_ms, restart
// out       output     out_valid / out_ready  due, rate_code
// cfg       input      cfg_we                 cfg_wdata (sample_rate)
//
// A beat that needs no arithmetic (restart, unlimited rate, time not past the
// timestamp) goes straight to ST_FIN, which loads the result register. Otherwise
// it waits for the 16-step serial multiply, and also for the 10-step divide for
// the catch-up step when that follows. One beat is in work at a time.
// Reset sets the rate to -1 and the timestamp to zero. A held result does not
// block the work on the next beat until that result is ready to go out.
module sample_pacer_with_catchup_core import spc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [RATE_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [NOW_W-1:0]  now_ms,
	input  logic              restart,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              due,
	output logic [CODE_W-1:0] rate_code
);

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_FIN} state_t;

	state_t                   state_q;
	logic signed [RATE_W-1:0] sample_rate_q;
	logic [NOW_W-1:0]         last_q;
	logic [NOW_W-1:0]         now_q;
	logic [NOW_W-1:0]         elapsed_q;
	logic                     pend_due_q;
	logic                     out_valid_q;
	logic                     due_q;
	logic [CODE_W-1:0]        rate_code_q;

	ar_ctl_t                  ctl;
	ar_sts_t                  sts;
	logic [PROD_W-1:0]        product;
	logic [MS_W-1:0]          quotient;

	logic                     accept;
	logic                     load_out;
	logic                     rate_neg;
	logic [RATE_W-1:0]        rate_mag;
	logic [NOW_W-1:0]         elapsed_now;
	logic [NOW_W-1:0]         op_a;
	logic [RATE_W-1:0]        op_b;
	logic                     beyond_twice;
	logic                     beyond_once;
	logic                     below_once;
	logic                     below_twice;

	// Operand selection and the compares made when the product is ready.
	always_comb begin
		accept       = in_valid && in_ready;
		load_out     = (state_q == ST_FIN) && (!out_valid_q || out_ready);
		rate_neg     = sample_rate_q[RATE_W-1];
		rate_mag     = ~sample_rate_q + 1'b1;
		elapsed_now  = now_ms - last_q;
		op_a         = rate_neg ? NOW_W'(MS_PER_SECOND) : elapsed_now;
		op_b         = rate_neg ? rate_mag : sample_rate_q;
		beyond_twice = ((PROD_W + 1)'(elapsed_q) > {product, 1'b0});
		beyond_once  = (PROD_W'(elapsed_q) > product);
		below_once   = (product < PROD_W'(MS_PER_SECOND));
		below_twice  = (product < PROD_W'(2 * MS_PER_SECOND));
		ctl.start_mul = accept && !restart && (sample_rate_q != '0) && (now_ms > last_q);
		ctl.start_div = (state_q == ST_MUL) && sts.done && !rate_neg && !below_twice;
	end

	spc_serial_arith u_arith (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.op_a     (op_a),
		.op_b     (op_b),
		.sts      (sts),
		.product  (product),
		.quotient (quotient)
	);

	// Control FSM with the timestamp, rate register and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			sample_rate_q <= RATE_RESET;
			last_q        <= '0;
			now_q         <= '0;
			elapsed_q     <= '0;
			pend_due_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			due_q         <= 1'b0;
			rate_code_q   <= '0;
		end else begin
			if (cfg_we) begin
				sample_rate_q <= cfg_wdata;
			end
			// A new result beat takes the output register; otherwise a taken beat leaves it.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						now_q     <= now_ms;
						elapsed_q <= elapsed_now;
						if (restart) begin
							last_q     <= now_ms;
							pend_due_q <= 1'b0;
							state_q    <= ST_FIN;
						end else if (sample_rate_q == '0) begin
							pend_due_q <= 1'b1;
							state_q    <= ST_FIN;
						end else if (now_ms <= last_q) begin
							pend_due_q <= 1'b0;
							state_q    <= ST_FIN;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (sts.done) begin
						if (rate_neg) begin
							// Product is the interval in milliseconds.
							if (beyond_twice) begin
								last_q     <= last_q + product[NOW_W-1:0];
								pend_due_q <= 1'b1;
							end else if (beyond_once) begin
								last_q     <= now_q;
								pend_due_q <= 1'b1;
							end else begin
								pend_due_q <= 1'b0;
							end
							state_q <= ST_FIN;
						end else if (below_once) begin
							pend_due_q <= 1'b0;
							state_q    <= ST_FIN;
						end else if (below_twice) begin
							last_q     <= now_q;
							pend_due_q <= 1'b1;
							state_q    <= ST_FIN;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					// At least two intervals behind: advance by one step.
					if (sts.done) begin
						last_q     <= last_q + NOW_W'(quotient);
						pend_due_q <= 1'b1;
						state_q    <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (load_out) begin
						due_q       <= pend_due_q;
						rate_code_q <= rate_band(sample_rate_q);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE) && !sts.busy;
	assign out_valid = out_valid_q;
	assign due       = due_q;
	assign rate_code = rate_code_q;

endmodule

### rtl/spc_checker.sv
// Port-level checks for the sample pacer, bound to the top level.
// Depends on spc_pkg.
module spc_checker import spc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic              due,
	input logic [CODE_W-1:0] rate_code
);

	// A stalled result beat holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(due) && $stable(rate_code))
		else $error("result beat changed while stalled");

	// Only one beat is in work: no acceptance right after an acceptance.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a beat was in work");

	// A new result only appears after a beat was in work.
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a beat in work");

	// The data-rate code is a band code or the unlimited code.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rate_code < CODE_W'(NUM_BANDS)) || (rate_code == CODE_UNLIMITED))
		else $error("rate code out of range");

endmodule

bind sample_pacer_with_catchup_core spc_checker u_spc_checker (.*);
